[sv/sbv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbv_pkg: shared types and codes for the sparse brick volume store
// Beat payloads, the job record passed from front to back, and dimension set.
// ----------------------------------------------------------------------------
package sbv_pkg;

    // largest voxel count per axis; coordinate and dimension widths follow it
    localparam int MAX_DIM = 64;
    localparam int COORD_W = 6;
    localparam int DIM_W   = 7;
    localparam int LIN_W   = 18;
    localparam int VAL_W   = 32;

    // action codes
    localparam logic [1:0] ACT_STORE  = 2'd0;
    localparam logic [1:0] ACT_RD_LIN = 2'd1;
    localparam logic [1:0] ACT_RD_XYZ = 2'd2;
    localparam logic [1:0] ACT_GATHER = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DEPTH  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [LIN_W-1:0]   linear_index;
        logic [VAL_W-1:0]   write_value;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic [COORD_W-1:0] z_coord;
        logic [COORD_W-1:0] x_upper;
        logic [COORD_W-1:0] y_upper;
        logic [COORD_W-1:0] z_upper;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [2:0]       corner;
        logic             last;
    } t_out;

    // decoded work item: coordinates resolved, linear index out of range flagged
    typedef struct packed {
        logic [1:0]         action;
        logic               oob;
        logic [VAL_W-1:0]   value;
        logic [COORD_W-1:0] xl;
        logic [COORD_W-1:0] yl;
        logic [COORD_W-1:0] zl;
        logic [COORD_W-1:0] xu;
        logic [COORD_W-1:0] yu;
        logic [COORD_W-1:0] zu;
    } t_job;

    // effective (clamped) volume dimensions
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] d;
    } t_dims;

endpackage
`default_nettype wire

[sv/sbv_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbv_front: input acceptance and linear index split
// Splits a linear index into x,y,z by two 6-step restoring divisions.
// ----------------------------------------------------------------------------
module sbv_front import sbv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_dims i_dims,
    input  wire logic  i_hold,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_in   i_in,
    output logic       o_push,
    output t_job       o_job,
    input  wire logic  i_full
);

    localparam int STEP_W = $clog2(COORD_W);
    localparam int SH_W   = LIN_W + COORD_W + 1;

    typedef enum logic [2:0] {F_IDLE, F_AREA, F_TOT, F_CHK, F_DZ, F_DY, F_PUSH} t_fstate;

    t_fstate                r_state;
    t_job                   r_job;
    logic [LIN_W-1:0]       r_idx;
    logic [2*DIM_W-1:0]     r_area;
    logic [3*DIM_W-1:0]     r_tot;
    logic [LIN_W-1:0]       r_rem;
    logic [STEP_W-1:0]      r_step;

    logic [SH_W-1:0] n_shz, n_shy;

    assign n_shz   = SH_W'(r_area) << r_step;
    assign n_shy   = SH_W'(i_dims.w) << r_step;
    assign o_ready = (r_state == F_IDLE) && !i_hold;
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_job   = r_job;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_job.action <= i_in.action;
                        r_job.oob    <= 1'b0;
                        r_job.value  <= i_in.write_value;
                        r_job.xl     <= i_in.x_coord;
                        r_job.yl     <= i_in.y_coord;
                        r_job.zl     <= i_in.z_coord;
                        r_job.xu     <= i_in.x_upper;
                        r_job.yu     <= i_in.y_upper;
                        r_job.zu     <= i_in.z_upper;
                        r_idx        <= i_in.linear_index;
                        if (i_in.action == ACT_STORE || i_in.action == ACT_RD_LIN)
                            r_state <= F_AREA;
                        else
                            r_state <= F_PUSH;
                    end
                end
                F_AREA: begin
                    r_area  <= (2*DIM_W)'(i_dims.w) * (2*DIM_W)'(i_dims.h);
                    r_state <= F_TOT;
                end
                F_TOT: begin
                    r_tot   <= (3*DIM_W)'(r_area) * (3*DIM_W)'(i_dims.d);
                    r_state <= F_CHK;
                end
                F_CHK: begin
                    r_rem    <= r_idx;
                    r_step   <= STEP_W'(COORD_W - 1);
                    r_job.xl <= '0;
                    r_job.yl <= '0;
                    r_job.zl <= '0;
                    if ((3*DIM_W+1)'(r_idx) >= (3*DIM_W+1)'(r_tot)) begin
                        r_job.oob <= 1'b1;
                        r_state   <= F_PUSH;
                    end else begin
                        r_state <= F_DZ;
                    end
                end
                F_DZ: begin
                    if (SH_W'(r_rem) >= n_shz) begin
                        r_rem <= LIN_W'(SH_W'(r_rem) - n_shz);
                        r_job.zl[r_step] <= 1'b1;
                    end
                    if (r_step == '0) begin
                        r_step  <= STEP_W'(COORD_W - 1);
                        r_state <= F_DY;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                F_DY: begin
                    if (SH_W'(r_rem) >= n_shy) begin
                        r_rem <= LIN_W'(SH_W'(r_rem) - n_shy);
                        r_job.yl[r_step] <= 1'b1;
                    end
                    if (r_step == '0)
                        r_state <= F_PUSH;
                    else
                        r_step <= r_step - 1'b1;
                end
                F_PUSH: begin
                    if (!i_full)
                        r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
            // remainder after both divisions is x
            if (r_state == F_DY && r_step == '0) begin
                if (SH_W'(r_rem) >= n_shy)
                    r_job.xl <= COORD_W'(SH_W'(r_rem) - n_shy);
                else
                    r_job.xl <= r_rem[COORD_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

[sv/sbv_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbv_fifo: two-entry job queue between front and back
// ----------------------------------------------------------------------------
module sbv_fifo import sbv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop)
                r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

[sv/sbv_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbv_back: brick table, voxel store, backing sweep, collapse scan, results
// One point at a time: brick address math, table lookup, voxel lookup.
// ----------------------------------------------------------------------------
module sbv_back import sbv_pkg::*; #(
    parameter int LOG2_BRICK_DIM = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_dims i_dims,
    input  wire logic  i_job_valid,
    input  wire t_job  i_job,
    output logic       o_pop,
    output logic       o_clearing,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_out       o_out
);

    localparam int L          = LOG2_BRICK_DIM;
    localparam int BD         = 1 << L;
    localparam int BA         = (MAX_DIM + BD - 1) / BD;
    localparam int BRICK_CNT  = BA * BA * BA;
    localparam int BW         = (BRICK_CNT > 1) ? $clog2(BRICK_CNT) : 1;
    localparam int OFF_W      = 3 * L;
    localparam int VOX_DEPTH  = BRICK_CNT << OFF_W;
    localparam int VA_W       = BW + OFF_W;
    localparam int NB_W       = DIM_W + 1;

    typedef enum logic [3:0] {
        B_CLR, B_IDLE, B_IX1, B_IX2, B_BRK, B_BRKW, B_OUT,
        B_ZERO, B_WR, B_SCAN, B_SCANW, B_COL
    } t_bstate;

    typedef struct packed {
        logic             backed;
        logic [VAL_W-1:0] value;
    } t_brick;

    t_brick           brick_mem [BRICK_CNT];
    logic [VAL_W-1:0] vox_mem   [VOX_DEPTH];

    t_bstate          r_state;
    t_job             r_job;
    logic [2:0]       r_k;
    logic             r_inr;
    logic [BW-1:0]    r_t, r_b, r_ccnt;
    logic [OFF_W-1:0] r_off, r_vcnt;
    logic [VAL_W-1:0] r_val, r_first;
    logic             r_eq, r_sv, r_s0;
    logic             r_ovalid;
    t_out             r_out;
    t_brick           r_brk_q;
    logic [VAL_W-1:0] r_vox_q;

    logic [COORD_W-1:0] n_px, n_py, n_pz;
    logic [NB_W-1:0]    n_nbx, n_nby;
    logic               n_last;
    logic               n_bwe;
    logic [BW-1:0]      n_bwa;
    t_brick             n_bwd;
    logic               n_vwe;
    logic [VA_W-1:0]    n_vwa, n_vra;
    logic [VAL_W-1:0]   n_vwd;

    // current point from corner number
    assign n_px  = r_k[0] ? r_job.xu : r_job.xl;
    assign n_py  = r_k[1] ? r_job.yu : r_job.yl;
    assign n_pz  = r_k[2] ? r_job.zu : r_job.zl;
    assign n_nbx = (NB_W'(i_dims.w) + NB_W'(BD - 1)) >> L;
    assign n_nby = (NB_W'(i_dims.h) + NB_W'(BD - 1)) >> L;
    assign n_last = (r_job.action != ACT_GATHER) || (r_k == 3'd7);

    assign o_pop      = (r_state == B_IDLE) && i_job_valid;
    assign o_clearing = (r_state == B_CLR);
    assign o_valid    = r_ovalid;
    assign o_out      = r_out;

    // memory port control
    always_comb begin
        n_bwe = 1'b0;
        n_bwa = r_b;
        n_bwd = '{backed: 1'b1, value: r_brk_q.value};
        n_vwe = 1'b0;
        n_vwa = {r_b, r_off};
        n_vwd = r_job.value;
        n_vra = {r_b, r_off};
        unique case (r_state)
            B_CLR: begin
                n_bwe = 1'b1;
                n_bwa = r_ccnt;
                n_bwd = '0;
            end
            B_BRKW: n_bwe = (r_job.action == ACT_STORE) && r_inr && !r_brk_q.backed;
            B_ZERO: begin
                n_vwe = 1'b1;
                n_vwa = {r_b, r_vcnt};
                n_vwd = '0;
            end
            B_WR:   n_vwe = 1'b1;
            B_SCAN: n_vra = {r_b, r_vcnt};
            B_COL: begin
                n_bwe = r_eq;
                n_bwd = '{backed: 1'b0, value: r_first};
            end
            default: ;
        endcase
    end

    // brick table
    always_ff @(posedge i_clk) begin
        if (n_bwe)
            brick_mem[n_bwa] <= n_bwd;
        r_brk_q <= brick_mem[r_b];
    end

    // voxel store
    always_ff @(posedge i_clk) begin
        if (n_vwe)
            vox_mem[n_vwa] <= n_vwd;
        r_vox_q <= vox_mem[n_vra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLR;
            r_ccnt   <= '0;
            r_ovalid <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            // B_OUT refills the result register itself
            if (r_ovalid && i_ready && r_state != B_OUT)
                r_ovalid <= 1'b0;
            // scan data arrives in the cycle after its read
            r_sv <= (r_state == B_SCAN);
            r_s0 <= (r_vcnt == '0);
            if (r_sv) begin
                if (r_s0) begin
                    r_first <= r_vox_q;
                    r_eq    <= 1'b1;
                end else if (r_vox_q != r_first) begin
                    r_eq <= 1'b0;
                end
            end
            unique case (r_state)
                B_CLR: begin
                    r_ccnt <= r_ccnt + 1'b1;
                    if (r_ccnt == BW'(BRICK_CNT - 1))
                        r_state <= B_IDLE;
                end
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_k     <= 3'd0;
                        r_state <= B_IX1;
                    end
                end
                B_IX1: begin
                    r_inr <= !r_job.oob && (DIM_W'(n_px) < i_dims.w)
                             && (DIM_W'(n_py) < i_dims.h) && (DIM_W'(n_pz) < i_dims.d);
                    r_t   <= BW'(BW'(n_pz >> L) * BW'(n_nby) + BW'(n_py >> L));
                    r_off <= {n_pz[L-1:0], n_py[L-1:0], n_px[L-1:0]};
                    r_state <= B_IX2;
                end
                B_IX2: begin
                    r_b     <= BW'(r_t * BW'(n_nbx) + BW'(n_px >> L));
                    r_state <= B_BRK;
                end
                B_BRK: r_state <= B_BRKW;
                B_BRKW: begin
                    if (r_job.action == ACT_STORE) begin
                        r_vcnt <= '0;
                        if (!r_inr)
                            r_state <= B_IDLE;
                        else if (!r_brk_q.backed)
                            r_state <= B_ZERO;
                        else
                            r_state <= B_WR;
                    end else begin
                        if (!r_inr)
                            r_val <= '0;
                        else if (!r_brk_q.backed)
                            r_val <= r_brk_q.value;
                        else
                            r_val <= r_vox_q;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_out    <= '{read_value: r_val, corner: r_k, last: n_last};
                        r_ovalid <= 1'b1;
                        if (n_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= B_IX1;
                        end
                    end
                end
                B_ZERO: begin
                    r_vcnt <= r_vcnt + 1'b1;
                    if (r_vcnt == '1)
                        r_state <= B_WR;
                end
                B_WR: begin
                    r_vcnt <= '0;
                    if (r_off == '1)
                        r_state <= B_SCAN;
                    else
                        r_state <= B_IDLE;
                end
                B_SCAN: begin
                    r_vcnt <= r_vcnt + 1'b1;
                    if (r_vcnt == '1)
                        r_state <= B_SCANW;
                end
                B_SCANW: r_state <= B_COL;
                B_COL:   r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/sparse_brick_volume_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_brick_volume_store: bricked voxel volume with uniform brick collapse
//
//  channel  | valid    | ready       | payload
//  ---------+----------+-------------+-----------------------------
//  input    | i_valid  | o_ready     | i_in  (t_in)
//  result   | o_valid  | i_ready     | o_out (t_out)
//  config   | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// Read: a point at xyz skips the front's split; one by linear index first runs
// two 6-step divides in the front. Gather: the corners go out one per beat,
// bound by the one-point-at-a-time brick/voxel lookup. A store that gives a
// brick backing adds a sweep that zeroes the brick's voxels; writing a brick's
// last voxel adds a collapse scan. After reset the brick table is cleared with
// o_ready low. Result stalls back up through the job queue into the front.
// ----------------------------------------------------------------------------
module sparse_brick_volume_store import sbv_pkg::*; #(
    parameter int LOG2_BRICK_DIM = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_in              i_in,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_out                  o_out,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [DIM_W-1:0] i_cfg_data
);

    logic [DIM_W-1:0] r_cfg_w, r_cfg_h, r_cfg_d;
    t_dims            n_dims;
    logic             n_push, n_full, n_pop, n_qvalid, n_clearing;
    t_job             n_fjob, n_qjob;

    function automatic logic [DIM_W-1:0] f_eff(input logic [DIM_W-1:0] r);
        if (r == '0)
            return DIM_W'(1);
        if (32'(r) > MAX_DIM)
            return DIM_W'(MAX_DIM);
        return r;
    endfunction

    assign n_dims      = '{w: f_eff(r_cfg_w), h: f_eff(r_cfg_h), d: f_eff(r_cfg_d)};
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DIM_W'(64);
            r_cfg_h <= DIM_W'(64);
            r_cfg_d <= DIM_W'(64);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                CFG_DEPTH:  r_cfg_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sbv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dims  (n_dims),
        .i_hold  (n_clearing),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_push  (n_push),
        .o_job   (n_fjob),
        .i_full  (n_full)
    );

    sbv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .i_job   (n_fjob),
        .o_full  (n_full),
        .i_pop   (n_pop),
        .o_valid (n_qvalid),
        .o_job   (n_qjob)
    );

    sbv_back #(
        .LOG2_BRICK_DIM (LOG2_BRICK_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (n_dims),
        .i_job_valid (n_qvalid),
        .i_job       (n_qjob),
        .o_pop       (n_pop),
        .o_clearing  (n_clearing),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
